// ----- rtl/core/sample_buffer_pool_allocator_unit_defines.svh -----
// assertion helpers for the buffer pool allocator
`ifndef SAMPLE_BUFFER_POOL_ALLOCATOR_UNIT_DEFINES_SVH
`define SAMPLE_BUFFER_POOL_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SBPA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define SBPA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/sbpa_pkg.sv -----
package sbpa_pkg;

   localparam int MAX_GENERAL = 256;
   localparam int MAX_STREAMS = 8;
   localparam int OFFSET_BITS = 24;

   localparam int POOL_W        = 24;
   localparam int STREAMS_CFG_W = 4;
   localparam int SIZE_W        = 16;
   localparam int CMD_W         = 2;
   localparam int STATUS_W      = 2;
   localparam int CSR_INDEX_W   = 4;
   localparam int CSR_DATA_W    = 24;

   localparam int GEN_IDX_W = $clog2(MAX_GENERAL);
   localparam int GEN_CNT_W = $clog2(MAX_GENERAL + 1);
   localparam int STK_IDX_W = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
   localparam int STK_CNT_W = $clog2(MAX_STREAMS + 1);

   localparam int USED_W = SIZE_W + STK_CNT_W;
   localparam int ACC_BASE_W = (OFFSET_BITS > POOL_W) ?
      ((OFFSET_BITS > USED_W) ? OFFSET_BITS : USED_W) :
      ((POOL_W > USED_W) ? POOL_W : USED_W);
   localparam int ACC_W = ACC_BASE_W + 1;

   typedef logic [OFFSET_BITS-1:0] offset_type;
   typedef logic [SIZE_W-1:0]      size_type;
   typedef logic [CMD_W-1:0]       cmd_type;
   typedef logic [STATUS_W-1:0]    status_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic [CSR_DATA_W-1:0]  csr_data_type;

   localparam cmd_type CMD_INIT       = CMD_W'(0);
   localparam cmd_type CMD_TAKE_GEN   = CMD_W'(1);
   localparam cmd_type CMD_TAKE_FIRST = CMD_W'(2);
   localparam cmd_type CMD_RECYCLE    = CMD_W'(3);

   localparam status_type ST_OK       = STATUS_W'(0);
   localparam status_type ST_NONE     = STATUS_W'(1);
   localparam status_type ST_SMALL    = STATUS_W'(2);
   localparam status_type ST_OVERFLOW = STATUS_W'(3);

   localparam csr_index_type CSR_POOL_BYTES    = CSR_INDEX_W'(0);
   localparam csr_index_type CSR_STREAM_COUNT  = CSR_INDEX_W'(1);
   localparam csr_index_type CSR_FIRST_BYTES   = CSR_INDEX_W'(2);
   localparam csr_index_type CSR_GENERAL_BYTES = CSR_INDEX_W'(3);

   localparam logic [POOL_W-1:0]        POOL_RESET    = POOL_W'(65536);
   localparam logic [STREAMS_CFG_W-1:0] STREAMS_RESET = STREAMS_CFG_W'(1);
   localparam size_type                 FIRST_RESET   = SIZE_W'(4096);
   localparam size_type                 GENERAL_RESET = SIZE_W'(4096);

endpackage

// ----- rtl/core/sample_buffer_pool_allocator_unit.sv -----
// Buffer pool allocator. Requests come in on the req_ channel (cmd, return
// offset, return kind); each request gives exactly one result on the rsp_
// channel (status, offset, size, kind), in order. Both channels transfer at
// a clock edge with valid high and stall low. Registers are written through
// the csr_ port, which is always ready; the user must write them only while
// no request is open, as the block itself does not enforce it. Take-first,
// recycle and failed takes go from idle to the result state, which loads
// the output register; a general take adds a state for the registered read
// of the general ring memory. Init walks one buffer per cycle through the
// shared offset adder: stream buffers, a pool check, then general buffers.
// req_stall is high from a transfer until its result sits in the output
// register; a new request is taken while that result still waits.
// If the receiver stalls, the result is held and a finished next result
// waits in the core, which then stalls the request side.
// Reset (synchronous) restores the register defaults and empties both
// pools; ring and stack contents are left as they are and are only read
// after being written.
module sample_buffer_pool_allocator_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  sbpa_pkg::cmd_type            req_cmd,
   input  sbpa_pkg::offset_type         req_return_offset,
   input  logic                         req_return_is_first,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output sbpa_pkg::status_type         rsp_status,
   output sbpa_pkg::offset_type         rsp_buf_offset,
   output sbpa_pkg::size_type           rsp_buf_bytes,
   output logic                         rsp_buf_is_first,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  sbpa_pkg::csr_index_type      csr_index,
   input  sbpa_pkg::csr_data_type       csr_wdata
);
   import sbpa_pkg::*;
   `include "sample_buffer_pool_allocator_unit_defines.svh"

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_FIRST = 3'd1;
   localparam logic [2:0] S_CHECK = 3'd2;
   localparam logic [2:0] S_GEN   = 3'd3;
   localparam logic [2:0] S_GREAD = 3'd4;
   localparam logic [2:0] S_PUT   = 3'd5;

   localparam logic [GEN_CNT_W-1:0] GEN_FULL   = GEN_CNT_W'(MAX_GENERAL);
   localparam logic [STK_CNT_W-1:0] STK_FULL   = STK_CNT_W'(MAX_STREAMS);
   localparam logic [GEN_IDX_W:0]   GEN_WRAP   = (GEN_IDX_W + 1)'(MAX_GENERAL);
   localparam logic [GEN_IDX_W-1:0] GEN_LAST   = GEN_IDX_W'(MAX_GENERAL - 1);

   logic [2:0]               state_ff, state_in;
   logic [POOL_W-1:0]        pool_ff, pool_in;
   logic [STREAMS_CFG_W-1:0] streams_cfg_ff, streams_cfg_in;
   size_type                 first_bytes_ff, first_bytes_in;
   size_type                 general_bytes_ff, general_bytes_in;
   logic [GEN_IDX_W-1:0]     head_ff, head_in;
   logic [GEN_CNT_W-1:0]     gcount_ff, gcount_in;
   logic [STK_CNT_W-1:0]     fcount_ff, fcount_in;
   logic [STK_CNT_W-1:0]     sidx_ff, sidx_in;
   logic [ACC_W-1:0]         acc_ff, acc_in;
   status_type               res_status_ff, res_status_in;
   offset_type               res_offset_ff, res_offset_in;
   size_type                 res_bytes_ff, res_bytes_in;
   logic                     res_first_ff, res_first_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   offset_type               rsp_offset_ff, rsp_offset_in;
   size_type                 rsp_bytes_ff, rsp_bytes_in;
   logic                     rsp_first_ff, rsp_first_in;

   offset_type               first_stack_ff [MAX_STREAMS];
   logic                     stack_we;
   logic [STK_IDX_W-1:0]     stack_waddr;
   offset_type               stack_wdata;

   logic                     ram_we;
   logic [GEN_IDX_W-1:0]     ram_waddr;
   offset_type               ram_wdata;
   offset_type               ram_rdata;

   logic [STK_CNT_W-1:0]     streams;
   logic [STK_CNT_W-1:0]     fcount_dec;
   size_type                 add_b;
   logic [ACC_W-1:0]         add_sum;
   logic [ACC_W-1:0]         pool_ext;
   logic [GEN_IDX_W:0]       tail_sum;
   logic [GEN_IDX_W-1:0]     tail;
   logic [GEN_IDX_W-1:0]     head_next;
   logic                     req_fire;
   logic                     put_go;

   assign streams = (int'(streams_cfg_ff) > MAX_STREAMS) ? STK_CNT_W'(MAX_STREAMS)
                                                         : STK_CNT_W'(streams_cfg_ff);
   assign fcount_dec = fcount_ff - 1'b1;
   assign add_b      = (state_ff == S_FIRST) ? first_bytes_ff : general_bytes_ff;
   assign add_sum    = acc_ff + ACC_W'(add_b);
   assign pool_ext   = ACC_W'(pool_ff);
   assign tail_sum   = {1'b0, head_ff} + {1'b0, gcount_ff[GEN_IDX_W-1:0]};
   assign tail       = (tail_sum >= GEN_WRAP) ? GEN_IDX_W'(tail_sum - GEN_WRAP)
                                              : tail_sum[GEN_IDX_W-1:0];
   assign head_next  = (head_ff == GEN_LAST) ? '0 : head_ff + 1'b1;
   assign req_fire   = req_valid && !req_stall;
   assign put_go     = (state_ff == S_PUT) && (!rsp_valid_ff || !rsp_stall);

   sbpa_ram #(
      .WIDTH(OFFSET_BITS),
      .DEPTH(MAX_GENERAL)
   ) u_general_ring (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(head_ff),
      .rdata(ram_rdata)
   );

   always_comb begin
      state_in         = state_ff;
      pool_in          = pool_ff;
      streams_cfg_in   = streams_cfg_ff;
      first_bytes_in   = first_bytes_ff;
      general_bytes_in = general_bytes_ff;
      head_in          = head_ff;
      gcount_in        = gcount_ff;
      fcount_in        = fcount_ff;
      sidx_in          = sidx_ff;
      acc_in           = acc_ff;
      res_status_in    = res_status_ff;
      res_offset_in    = res_offset_ff;
      res_bytes_in     = res_bytes_ff;
      res_first_in     = res_first_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_status_in    = rsp_status_ff;
      rsp_offset_in    = rsp_offset_ff;
      rsp_bytes_in     = rsp_bytes_ff;
      rsp_first_in     = rsp_first_ff;
      stack_we         = 1'b0;
      stack_waddr      = fcount_ff[STK_IDX_W-1:0];
      stack_wdata      = req_return_offset;
      ram_we           = 1'b0;
      ram_waddr        = tail;
      ram_wdata        = req_return_offset;

      if (csr_valid) begin
         case (csr_index)
            CSR_POOL_BYTES:    pool_in          = csr_wdata[POOL_W-1:0];
            CSR_STREAM_COUNT:  streams_cfg_in   = csr_wdata[STREAMS_CFG_W-1:0];
            CSR_FIRST_BYTES:   first_bytes_in   = csr_wdata[SIZE_W-1:0];
            CSR_GENERAL_BYTES: general_bytes_in = csr_wdata[SIZE_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: if (req_valid) begin
            res_status_in = ST_OK;
            res_offset_in = '0;
            res_bytes_in  = '0;
            res_first_in  = 1'b0;
            state_in      = S_PUT;
            case (req_cmd)
               CMD_INIT: begin
                  head_in  = '0;
                  gcount_in = '0;
                  fcount_in = '0;
                  sidx_in  = '0;
                  acc_in   = '0;
                  state_in = S_FIRST;
               end
               CMD_TAKE_GEN: begin
                  if (gcount_ff == '0) begin
                     res_status_in = ST_NONE;
                  end else begin
                     state_in = S_GREAD;
                  end
               end
               CMD_TAKE_FIRST: begin
                  if (fcount_ff == '0) begin
                     res_status_in = ST_NONE;
                  end else begin
                     fcount_in     = fcount_dec;
                     res_offset_in = first_stack_ff[fcount_dec[STK_IDX_W-1:0]];
                     res_bytes_in  = first_bytes_ff;
                     res_first_in  = 1'b1;
                  end
               end
               default: begin
                  if (req_return_is_first) begin
                     if (fcount_ff >= STK_FULL) begin
                        res_status_in = ST_OVERFLOW;
                     end else begin
                        stack_we  = 1'b1;
                        fcount_in = fcount_ff + 1'b1;
                     end
                  end else begin
                     if (gcount_ff >= GEN_FULL) begin
                        res_status_in = ST_OVERFLOW;
                     end else begin
                        ram_we    = 1'b1;
                        gcount_in = gcount_ff + 1'b1;
                     end
                  end
               end
            endcase
         end
         S_FIRST: begin
            if (sidx_ff == streams) begin
               state_in = S_CHECK;
            end else begin
               stack_we    = 1'b1;
               stack_waddr = sidx_ff[STK_IDX_W-1:0];
               stack_wdata = acc_ff[OFFSET_BITS-1:0];
               acc_in      = add_sum;
               sidx_in     = sidx_ff + 1'b1;
            end
         end
         S_CHECK: begin
            if (acc_ff >= pool_ext) begin
               res_status_in = ST_SMALL;
               state_in      = S_PUT;
            end else begin
               fcount_in = streams;
               state_in  = (general_bytes_ff == '0) ? S_PUT : S_GEN;
            end
         end
         S_GEN: begin
            if (add_sum > pool_ext) begin
               state_in = S_PUT;
            end else if (gcount_ff == GEN_FULL) begin
               res_status_in = ST_OVERFLOW;
               state_in      = S_PUT;
            end else begin
               ram_we    = 1'b1;
               ram_waddr = gcount_ff[GEN_IDX_W-1:0];
               ram_wdata = acc_ff[OFFSET_BITS-1:0];
               acc_in    = add_sum;
               gcount_in = gcount_ff + 1'b1;
            end
         end
         S_GREAD: begin
            res_offset_in = ram_rdata;
            res_bytes_in  = general_bytes_ff;
            res_first_in  = 1'b0;
            head_in       = head_next;
            gcount_in     = gcount_ff - 1'b1;
            state_in      = S_PUT;
         end
         S_PUT: begin
            if (put_go) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_offset_in = res_offset_ff;
               rsp_bytes_in  = res_bytes_ff;
               rsp_first_in  = res_first_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         pool_ff          <= POOL_RESET;
         streams_cfg_ff   <= STREAMS_RESET;
         first_bytes_ff   <= FIRST_RESET;
         general_bytes_ff <= GENERAL_RESET;
         head_ff          <= '0;
         gcount_ff        <= '0;
         fcount_ff        <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         pool_ff          <= pool_in;
         streams_cfg_ff   <= streams_cfg_in;
         first_bytes_ff   <= first_bytes_in;
         general_bytes_ff <= general_bytes_in;
         head_ff          <= head_in;
         gcount_ff        <= gcount_in;
         fcount_ff        <= fcount_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      sidx_ff       <= sidx_in;
      acc_ff        <= acc_in;
      res_status_ff <= res_status_in;
      res_offset_ff <= res_offset_in;
      res_bytes_ff  <= res_bytes_in;
      res_first_ff  <= res_first_in;
      rsp_status_ff <= rsp_status_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_bytes_ff  <= rsp_bytes_in;
      rsp_first_ff  <= rsp_first_in;
      if (stack_we) begin
         first_stack_ff[stack_waddr] <= stack_wdata;
      end
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_buf_offset   = rsp_offset_ff;
   assign rsp_buf_bytes    = rsp_bytes_ff;
   assign rsp_buf_is_first = rsp_first_ff;

   `SBPA_ASSERT_NOW(a_gcount_bound, 1'b1, gcount_ff <= GEN_FULL, "general count past capacity")
   `SBPA_ASSERT_NOW(a_fcount_bound, 1'b1, fcount_ff <= STK_FULL, "first count past capacity")
   `SBPA_ASSERT_NEXT(a_accept_busy, req_fire, state_ff != S_IDLE, "transfer left core idle")
   `SBPA_ASSERT_NOW(a_gread_nonempty, state_ff == S_GREAD, gcount_ff != '0, "read from empty ring")
   `SBPA_ASSERT_NEXT(a_put_loads, put_go, rsp_valid_ff && state_ff == S_IDLE, "result not loaded")

endmodule

// ----- rtl/core/sbpa_ram.sv -----
module sbpa_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import sbpa_pkg::*;

   typedef struct packed {
      status_type status;
      offset_type offset;
      size_type   bytes;
      logic       is_first;
   } pool_grant_type;

   typedef struct {
      offset_type offset;
      logic       is_first;
   } held_buf_type;

   logic          clock;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   cmd_type       req_cmd = CMD_INIT;
   offset_type    req_return_offset = '0;
   logic          req_return_is_first = 1'b0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   status_type    rsp_status;
   offset_type    rsp_buf_offset;
   size_type      rsp_buf_bytes;
   logic          rsp_buf_is_first;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = CSR_POOL_BYTES;
   csr_data_type  csr_wdata = '0;

   // register mirror
   logic [POOL_W-1:0]        cfg_pool = POOL_RESET;
   logic [STREAMS_CFG_W-1:0] cfg_streams = STREAMS_RESET;
   size_type                 cfg_first = FIRST_RESET;
   size_type                 cfg_general = GENERAL_RESET;

   // pool state mirror
   offset_type           gen_ring [MAX_GENERAL];
   logic [GEN_IDX_W-1:0] gen_head = '0;
   logic [GEN_CNT_W-1:0] gen_count = '0;
   offset_type           first_stk [MAX_STREAMS];
   logic [STK_CNT_W-1:0] first_cnt = '0;

   pool_grant_type pending_grants[$];
   held_buf_type   granted_bufs[$];
   int             mismatch_count = 0;
   int             stall_left = 0;
   bit             quiet = 1'b0;

   sample_buffer_pool_allocator_unit uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_return_offset(req_return_offset),
      .req_return_is_first(req_return_is_first),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_buf_offset(rsp_buf_offset),
      .rsp_buf_bytes(rsp_buf_bytes),
      .rsp_buf_is_first(rsp_buf_is_first),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic pool_grant_type predict_pool_command(cmd_type cmd, offset_type ret_off,
                                                           logic ret_first);
      pool_grant_type g;
      int unsigned streams, used, fit;
      g = '0;
      case (cmd)
         CMD_INIT: begin
            streams = (cfg_streams > MAX_STREAMS) ? MAX_STREAMS : cfg_streams;
            used = streams * cfg_first;
            gen_head = '0;
            gen_count = '0;
            first_cnt = '0;
            if (used >= cfg_pool) begin
               g.status = ST_SMALL;
            end else begin
               for (int i = 0; i < streams; i++)
                  first_stk[i] = offset_type'(i * cfg_first);
               first_cnt = STK_CNT_W'(streams);
               if (cfg_general != 0) begin
                  fit = (cfg_pool - used) / cfg_general;
                  if (fit > MAX_GENERAL) begin
                     fit = MAX_GENERAL;
                     g.status = ST_OVERFLOW;
                  end
                  for (int i = 0; i < fit; i++)
                     gen_ring[i] = offset_type'(used + i * cfg_general);
                  gen_count = GEN_CNT_W'(fit);
               end
            end
         end
         CMD_TAKE_GEN: begin
            if (gen_count == 0) begin
               g.status = ST_NONE;
            end else begin
               g.offset = gen_ring[gen_head];
               g.bytes = cfg_general;
               gen_head = GEN_IDX_W'((gen_head + 1) % MAX_GENERAL);
               gen_count = gen_count - 1'b1;
            end
         end
         CMD_TAKE_FIRST: begin
            if (first_cnt == 0) begin
               g.status = ST_NONE;
            end else begin
               first_cnt = first_cnt - 1'b1;
               g.offset = first_stk[first_cnt[STK_IDX_W-1:0]];
               g.bytes = cfg_first;
               g.is_first = 1'b1;
            end
         end
         CMD_RECYCLE: begin
            if (ret_first) begin
               if (first_cnt >= MAX_STREAMS) begin
                  g.status = ST_OVERFLOW;
               end else begin
                  first_stk[first_cnt[STK_IDX_W-1:0]] = ret_off;
                  first_cnt = first_cnt + 1'b1;
               end
            end else begin
               if (gen_count >= MAX_GENERAL) begin
                  g.status = ST_OVERFLOW;
               end else begin
                  gen_ring[GEN_IDX_W'((gen_head + gen_count) % MAX_GENERAL)] = ret_off;
                  gen_count = gen_count + 1'b1;
               end
            end
         end
      endcase
      return g;
   endfunction

   task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
      if (mismatch_count < 40)
         $display("%0t: %s mismatch, got %0h expected %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic issue_pool_command(cmd_type cmd, offset_type ret_off, logic ret_first);
      pool_grant_type g;
      g = predict_pool_command(cmd, ret_off, ret_first);
      pending_grants.push_back(g);
      if (cmd == CMD_INIT)
         granted_bufs.delete();
      else if (cmd != CMD_RECYCLE && g.status == ST_OK)
         granted_bufs.push_back('{g.offset, g.is_first});
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_return_offset <= ret_off;
      req_return_is_first <= ret_first;
      do @(posedge clock); while (req_stall !== 1'b0);
      if (!quiet && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   task automatic issue_random(cmd_type cmd);
      issue_pool_command(cmd, offset_type'($urandom), 1'($urandom_range(0, 1)));
   endtask

   task automatic recycle_held();
      int unsigned idx;
      held_buf_type b;
      if (granted_bufs.size() == 0) begin
         issue_random(CMD_RECYCLE);
      end else begin
         idx = $urandom_range(0, granted_bufs.size() - 1);
         b = granted_bufs[idx];
         granted_bufs.delete(idx);
         issue_pool_command(CMD_RECYCLE, b.offset, b.is_first);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, csr_data_type value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      case (idx)
         CSR_POOL_BYTES:    cfg_pool = value[POOL_W-1:0];
         CSR_STREAM_COUNT:  cfg_streams = value[STREAMS_CFG_W-1:0];
         CSR_FIRST_BYTES:   cfg_first = value[SIZE_W-1:0];
         CSR_GENERAL_BYTES: cfg_general = value[SIZE_W-1:0];
         default: ;
      endcase
   endtask

   task automatic run_pool_traffic(int count, int reinit_pct);
      int unsigned pick;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < reinit_pct)
            issue_random(CMD_INIT);
         else if (pick < 40)
            issue_random(CMD_TAKE_GEN);
         else if (pick < 58)
            issue_random(CMD_TAKE_FIRST);
         else if (pick < 92)
            recycle_held();
         else
            issue_random(cmd_type'($urandom_range(0, 3)));
      end
   endtask

   task automatic test_reset_defaults();
      issue_random(CMD_TAKE_GEN);
      issue_random(CMD_TAKE_FIRST);
      issue_pool_command(CMD_RECYCLE, 24'hABCDEF, 1'b1);
      issue_random(CMD_TAKE_FIRST);
      issue_random(CMD_INIT);
      issue_random(CMD_TAKE_FIRST);
      issue_random(CMD_TAKE_FIRST);
      issue_random(CMD_TAKE_GEN);
      recycle_held();
   endtask

   task automatic test_layout_limits();
      write_csr(CSR_POOL_BYTES, '0);
      write_csr(CSR_STREAM_COUNT, '0);
      issue_random(CMD_INIT);
      issue_random(CMD_TAKE_GEN);
      // first buffers fill the pool exactly
      write_csr(CSR_STREAM_COUNT, 2);
      write_csr(CSR_FIRST_BYTES, 100);
      write_csr(CSR_POOL_BYTES, 200);
      issue_random(CMD_INIT);
      write_csr(CSR_POOL_BYTES, 201);
      write_csr(CSR_GENERAL_BYTES, 24'h00FFFF);
      issue_random(CMD_INIT);
      issue_random(CMD_TAKE_GEN);
      issue_random(CMD_TAKE_FIRST);
      // stream count clamped, general count capped
      write_csr(CSR_STREAM_COUNT, 15);
      write_csr(CSR_FIRST_BYTES, 24'h00FFFF);
      write_csr(CSR_POOL_BYTES, 24'hFFFFFF);
      write_csr(CSR_GENERAL_BYTES, 1);
      issue_random(CMD_INIT);
      issue_random(CMD_TAKE_FIRST);
      issue_random(CMD_TAKE_GEN);
      // size follows the register after init
      write_csr(CSR_GENERAL_BYTES, 24'h00FFFF);
      issue_random(CMD_TAKE_GEN);
      write_csr(CSR_GENERAL_BYTES, 0);
      issue_random(CMD_INIT);
      issue_random(CMD_TAKE_GEN);
   endtask

   task automatic test_recycle_limits();
      write_csr(CSR_STREAM_COUNT, 8);
      write_csr(CSR_FIRST_BYTES, 1);
      write_csr(CSR_GENERAL_BYTES, 1);
      issue_random(CMD_INIT);
      issue_pool_command(CMD_RECYCLE, '0, 1'b1);
      issue_pool_command(CMD_RECYCLE, 24'h5A5A5A, 1'b0);
      issue_random(CMD_TAKE_GEN);
      issue_pool_command(CMD_RECYCLE, 24'hFFFFFF, 1'b0);
      issue_random(CMD_TAKE_FIRST);
      issue_pool_command(CMD_RECYCLE, 24'hFFFFFF, 1'b1);
      issue_random(CMD_TAKE_FIRST);
   endtask

   task automatic test_random_layouts();
      int unsigned streams, first, general, pool;
      for (int phase = 0; phase < 7; phase++) begin
         streams = $urandom_range(0, 10);
         if ($urandom_range(0, 3) == 0) begin
            first = $urandom_range(1, 65535);
            general = $urandom_range(0, 65535);
            pool = $urandom_range(0, 24'hFFFFFF);
         end else begin
            first = $urandom_range(1, 2048);
            general = $urandom_range(1, 4096);
            pool = (streams > MAX_STREAMS ? MAX_STREAMS : streams) * first
                   + general * $urandom_range(0, 300) + $urandom_range(0, general);
         end
         write_csr(CSR_POOL_BYTES, csr_data_type'(pool));
         write_csr(CSR_STREAM_COUNT, csr_data_type'(streams));
         write_csr(CSR_FIRST_BYTES, csr_data_type'(first));
         write_csr(CSR_GENERAL_BYTES, csr_data_type'(general));
         if ($urandom_range(0, 9) < 7)
            issue_random(CMD_INIT);
         run_pool_traffic(110, $urandom_range(0, 1) * 4);
      end
   endtask

   task automatic test_ring_wrap();
      write_csr(CSR_STREAM_COUNT, 0);
      write_csr(CSR_GENERAL_BYTES, 32);
      write_csr(CSR_POOL_BYTES, 167);
      issue_random(CMD_INIT);
      repeat (300) begin
         issue_random(CMD_TAKE_GEN);
         recycle_held();
      end
   endtask

   task automatic test_back_to_back();
      quiet = 1'b1;
      write_csr(CSR_STREAM_COUNT, 4);
      write_csr(CSR_FIRST_BYTES, 256);
      write_csr(CSR_GENERAL_BYTES, 512);
      write_csr(CSR_POOL_BYTES, 24'h004000);
      issue_random(CMD_INIT);
      run_pool_traffic(120, 2);
   endtask

   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 11) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 17);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      pool_grant_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_grants.size() == 0) begin
            report_mismatch("unexpected transfer", rsp_status, 0);
         end else begin
            want = pending_grants.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_buf_offset !== want.offset)
               report_mismatch("buf_offset", rsp_buf_offset, want.offset);
            if (rsp_buf_bytes !== want.bytes)
               report_mismatch("buf_bytes", rsp_buf_bytes, want.bytes);
            if (rsp_buf_is_first !== want.is_first)
               report_mismatch("buf_is_first", rsp_buf_is_first, want.is_first);
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_layout_limits();
      test_recycle_limits();
      test_random_layouts();
      test_ring_wrap();
      test_back_to_back();
      wait_idle();
      repeat (300) @(posedge clock);
      if (mismatch_count == 0 && pending_grants.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
